[rtl/core/zmb_pkg.sv]
package zmb_pkg;

  localparam int VALUE_W = 32;
  localparam int COLUMN_W = 3;
  localparam int COUNT_W = 5;

  typedef enum logic [1:0] {
    OP_CLEAR = 2'd0,
    OP_ADD   = 2'd1,
    OP_CHECK = 2'd2
  } op_t;

  typedef enum logic [2:0] {
    CMP_EQ = 3'd0,
    CMP_NE = 3'd1,
    CMP_LT = 3'd2,
    CMP_LE = 3'd3,
    CMP_GT = 3'd4,
    CMP_GE = 3'd5
  } cmp_t;

  typedef enum logic [1:0] {
    V_MAY_MATCH  = 2'd0,
    V_SKIP_RANGE = 2'd1,
    V_SKIP_SET   = 2'd2
  } verdict_t;

  typedef enum logic {
    ST_IDLE = 1'b0,
    ST_EXEC = 1'b1
  } state_t;

  // controller -> datapath
  typedef struct packed {
    logic load;
    logic exec;
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic is_check;
    logic out_busy;
  } status_t;

endpackage

[rtl/core/zmb_ram.sv]
module zmb_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 8
) (
  input  logic                                  clk,
  input  logic                                  we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                      wdata,
  input  logic                                  re,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                      rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

[rtl/core/zmb_ctrl.sv]
module zmb_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  zmb_pkg::status_t  status,
  output zmb_pkg::cmd_t     cmd
);

  zmb_pkg::state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= zmb_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    in_ready = 1'b0;
    cmd = '0;
    case (state)
      zmb_pkg::ST_IDLE: begin
        // no request is taken while reset is held
        in_ready = !rst;
        if (in_valid && !rst) begin
          cmd.load = 1'b1;
          state_next = zmb_pkg::ST_EXEC;
        end
      end
      zmb_pkg::ST_EXEC: begin
        // a check waits here while the result register is still held
        if (!(status.is_check && status.out_busy)) begin
          cmd.exec = 1'b1;
          state_next = zmb_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = zmb_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

[rtl/core/zmb_dp.sv]
module zmb_dp #(
  parameter int COLUMNS = 8,
  parameter int DISTINCT_SLOTS = 16
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  zmb_pkg::cmd_t                        cmd,
  output zmb_pkg::status_t                     status,
  input  logic [1:0]                           operation,
  input  logic [zmb_pkg::COLUMN_W-1:0]         column,
  input  logic signed [zmb_pkg::VALUE_W-1:0]   value,
  input  logic                                 is_null,
  input  logic [2:0]                           compare_op,
  input  logic                                 first_qual,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic [1:0]                           verdict,
  output logic signed [zmb_pkg::VALUE_W-1:0]   minimum,
  output logic signed [zmb_pkg::VALUE_W-1:0]   maximum,
  output logic [zmb_pkg::COUNT_W-1:0]          distinct_count,
  output logic                                 set_overflowed,
  output logic                                 has_value,
  output logic                                 saw_null
);

  localparam int VW = zmb_pkg::VALUE_W;
  localparam int CW = (COLUMNS > 1) ? $clog2(COLUMNS) : 1;
  localparam int XW = (CW > zmb_pkg::COLUMN_W) ? CW : zmb_pkg::COLUMN_W;
  localparam int CD = 1 << CW;
  localparam int FW = $clog2(DISTINCT_SLOTS + 1);
  localparam int SET_W = DISTINCT_SLOTS * VW;
  localparam int ROW_W = SET_W + 2 * VW;
  localparam logic [6:0] COLS_LIM = 7'(COLUMNS);
  localparam logic [FW-1:0] SLOTS_LIM = FW'(DISTINCT_SLOTS);

  // latched request
  logic [1:0]                  op_q;
  logic [zmb_pkg::COLUMN_W-1:0] col_q;
  logic signed [VW-1:0]        val_q;
  logic                        null_q;
  logic [2:0]                  cmp_q;
  logic                        first_q;

  // per-column flags
  logic          seen  [CD];
  logic          nseen [CD];
  logic          full  [CD];
  logic [FW-1:0] fill  [CD];

  logic [1:0] run_verdict;

  logic [XW-1:0]    in_ext, q_ext;
  logic [CW-1:0]    in_idx, idx;
  logic [ROW_W-1:0] row, row_new;
  logic             in_range;
  logic             hv, nv, fl;
  logic [FW-1:0]    fc;
  logic signed [VW-1:0] lo, hi, lo_new, hi_new;
  logic [DISTINCT_SLOTS-1:0] hit_v;
  logic             hit, room, insert;
  logic             is_add, is_check, is_clear, wr_row;
  logic             ok;
  logic [1:0]       here, vbase, vnew;

  assign in_ext = XW'(column);
  assign in_idx = in_ext[CW-1:0];
  assign q_ext  = XW'(col_q);
  assign idx    = q_ext[CW-1:0];

  zmb_ram #(
    .WIDTH (ROW_W),
    .DEPTH (COLUMNS)
  ) u_rows (
    .clk   (clk),
    .we    (wr_row),
    .waddr (idx),
    .wdata (row_new),
    .re    (cmd.load),
    .raddr (in_idx),
    .rdata (row)
  );

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_q    <= operation;
      col_q   <= column;
      val_q   <= value;
      null_q  <= is_null;
      cmp_q   <= compare_op;
      first_q <= first_qual;
    end
  end

  assign in_range = {4'd0, col_q} < COLS_LIM;
  assign hv = in_range & seen[idx];
  assign nv = in_range & nseen[idx];
  assign fl = in_range & full[idx];
  assign fc = in_range ? fill[idx] : '0;

  assign lo = row[SET_W +: VW];
  assign hi = row[SET_W + VW +: VW];

  always_comb begin
    for (int i = 0; i < DISTINCT_SLOTS; i++) begin
      hit_v[i] = (FW'(i) < fc) && (row[i*VW +: VW] == val_q);
    end
  end
  assign hit    = |hit_v;
  assign room   = fc < SLOTS_LIM;
  assign insert = !fl && !hit && room;

  assign lo_new = (!hv || (val_q < lo)) ? val_q : lo;
  assign hi_new = (!hv || (val_q > hi)) ? val_q : hi;

  always_comb begin
    row_new = row;
    row_new[SET_W +: VW] = lo_new;
    row_new[SET_W + VW +: VW] = hi_new;
    for (int i = 0; i < DISTINCT_SLOTS; i++) begin
      if (insert && (fc == FW'(i))) begin
        row_new[i*VW +: VW] = val_q;
      end
    end
  end

  assign is_clear = op_q == zmb_pkg::OP_CLEAR;
  assign is_add   = (op_q == zmb_pkg::OP_ADD) && in_range;
  assign is_check = op_q == zmb_pkg::OP_CHECK;
  assign wr_row   = cmd.exec && is_add && !null_q;

  always_comb begin
    ok = 1'b1;
    here = zmb_pkg::V_MAY_MATCH;
    case (cmp_q)
      zmb_pkg::CMP_EQ: ok = (val_q >= lo) && (val_q <= hi);
      zmb_pkg::CMP_NE: ok = (lo != val_q) || (hi != val_q);
      zmb_pkg::CMP_LT: ok = lo < val_q;
      zmb_pkg::CMP_LE: ok = lo <= val_q;
      zmb_pkg::CMP_GT: ok = hi > val_q;
      zmb_pkg::CMP_GE: ok = hi >= val_q;
      default:         ok = 1'b1;
    endcase
    if (cmp_q > zmb_pkg::CMP_GE) begin
      here = zmb_pkg::V_MAY_MATCH;
    end else if (null_q || !hv || !ok) begin
      here = zmb_pkg::V_SKIP_RANGE;
    end else if ((cmp_q == zmb_pkg::CMP_EQ) && !fl && !hit) begin
      here = zmb_pkg::V_SKIP_SET;
    end
    vbase = first_q ? zmb_pkg::V_MAY_MATCH : run_verdict;
    vnew  = (vbase == zmb_pkg::V_MAY_MATCH) ? here : vbase;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int c = 0; c < CD; c++) begin
        seen[c]  <= 1'b0;
        nseen[c] <= 1'b0;
        full[c]  <= 1'b0;
        fill[c]  <= '0;
      end
      run_verdict <= zmb_pkg::V_MAY_MATCH;
    end else if (cmd.exec) begin
      if (is_clear) begin
        for (int c = 0; c < CD; c++) begin
          seen[c]  <= 1'b0;
          nseen[c] <= 1'b0;
          full[c]  <= 1'b0;
          fill[c]  <= '0;
        end
      end else if (is_add) begin
        if (null_q) begin
          nseen[idx] <= 1'b1;
        end else begin
          seen[idx] <= 1'b1;
          if (insert) begin
            fill[idx] <= fc + FW'(1);
          end else if (!fl && !hit) begin
            full[idx] <= 1'b1;
          end
        end
      end else if (is_check) begin
        run_verdict <= vnew;
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.exec && is_check) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.exec && is_check) begin
      verdict        <= vnew;
      minimum        <= hv ? lo : '0;
      maximum        <= hv ? hi : '0;
      distinct_count <= zmb_pkg::COUNT_W'(fc);
      set_overflowed <= fl;
      has_value      <= hv;
      saw_null       <= nv;
    end
  end

  assign status.is_check = is_check;
  assign status.out_busy = out_valid && !out_ready;

endmodule

[rtl/core/zone_map_builder_and_pruner.sv]
// Zone-map builder and pruner for one storage group.
//
// Request channel (in_valid/in_ready): operation, column, value, is_null,
// compare_op, first_qual. A clear request empties every column, an add
// request records a value or a null, a check request tests one qualifier
// and yields one result on the out_valid/out_ready channel.
//
// Each request is accepted with a read of the column's row (bounds plus
// all distinct slots) from the row RAM; the execute state then does all
// slot compares in parallel and, for an add of a value, writes the row
// back. in_ready is high only in idle, so no new request is taken until
// the previous one has executed, which registers a check result onto out_valid.
//
// Results sit in an output register. If the receiver stalls, adds and
// clears keep flowing; a check waits in its execute state until the held
// result is taken. Reset clears all column flags and the running verdict;
// RAM rows need no clearing since they are read only under the flags.
module zone_map_builder_and_pruner #(
  parameter int COLUMNS = 8,
  parameter int DISTINCT_SLOTS = 16
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic [1:0]                         operation,
  input  logic [zmb_pkg::COLUMN_W-1:0]       column,
  input  logic signed [zmb_pkg::VALUE_W-1:0] value,
  input  logic                               is_null,
  input  logic [2:0]                         compare_op,
  input  logic                               first_qual,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic [1:0]                         verdict,
  output logic signed [zmb_pkg::VALUE_W-1:0] minimum,
  output logic signed [zmb_pkg::VALUE_W-1:0] maximum,
  output logic [zmb_pkg::COUNT_W-1:0]        distinct_count,
  output logic                               set_overflowed,
  output logic                               has_value,
  output logic                               saw_null
);

  zmb_pkg::cmd_t    cmd;
  zmb_pkg::status_t status;

  // sequencer: idle/accept, then execute
  zmb_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .status   (status),
    .cmd      (cmd)
  );

  // column flags, row RAM, compare logic and result register
  zmb_dp #(
    .COLUMNS        (COLUMNS),
    .DISTINCT_SLOTS (DISTINCT_SLOTS)
  ) u_dp (
    .clk            (clk),
    .rst            (rst),
    .cmd            (cmd),
    .status         (status),
    .operation      (operation),
    .column         (column),
    .value          (value),
    .is_null        (is_null),
    .compare_op     (compare_op),
    .first_qual     (first_qual),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .verdict        (verdict),
    .minimum        (minimum),
    .maximum        (maximum),
    .distinct_count (distinct_count),
    .set_overflowed (set_overflowed),
    .has_value      (has_value),
    .saw_null       (saw_null)
  );

endmodule
